/* sv/pcf_pkg.sv */
// Shared types, register codes and datapath step functions for the contact force block.
package pcf_pkg;

  // Pipeline depth of the square root and the two normal dividers
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 17;

  // Saturation limits of a force word
  localparam logic [31:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FORCE_MIN = 32'h8000_0000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_STIFF  = 2'd1,
    REG_DAMP   = 2'd2,
    REG_FRIC   = 2'd3
  } cfg_reg_t;

  // Side data that rides along the square root stages
  typedef struct packed {
    logic               contact;
    logic               sx;
    logic               sy;
    logic [30:0]        adx;
    logic [30:0]        ady;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
  } sq_carry_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    logic               contact;
    logic               sx;
    logic               sy;
    logic [30:0]        rdist;
    logic [30:0]        ovl;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
  } dv_carry_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
  } sq_step_t;

  typedef struct packed {
    logic [30:0] rem;
    logic        q;
  } dv_step_t;

  // One digit of the integer square root: bring down two bits, try 4*root+1
  function automatic sq_step_t sqrt_step(logic [32:0] rem, logic [30:0] root,
                                         logic [1:0] pair);
    logic [34:0] cur;
    logic [34:0] trial;
    sq_step_t    r;
    cur   = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (cur >= trial) begin
      r.rem  = 33'(cur - trial);
      r.root = {root[29:0], 1'b1};
    end else begin
      r.rem  = cur[32:0];
      r.root = {root[29:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring divide
  function automatic dv_step_t div_step(logic [30:0] rem, logic b, logic [30:0] dvsr);
    logic [31:0] cur;
    dv_step_t    r;
    cur = {rem, b};
    if (cur >= {1'b0, dvsr}) begin
      r.rem = 31'(cur - {1'b0, dvsr});
      r.q   = 1'b1;
    end else begin
      r.rem = cur[30:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

/* sv/pcf_if.sv */
// Valid/ready channel interfaces for particle pairs in and contact forces out.
interface pcf_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_a_x;
  logic signed [31:0] pos_a_y;
  logic signed [31:0] vel_a_x;
  logic signed [31:0] vel_a_y;
  logic signed [31:0] pos_b_x;
  logic signed [31:0] pos_b_y;
  logic signed [31:0] vel_b_x;
  logic signed [31:0] vel_b_y;

  modport source (output valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y,
                  pos_b_x, pos_b_y, vel_b_x, vel_b_y, input ready);
  modport sink (input valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y,
                pos_b_x, pos_b_y, vel_b_x, vel_b_y, output ready);
endinterface

interface pcf_force_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               in_contact;

  modport source (output valid, force_x, force_y, in_contact, input ready);
  modport sink (input valid, force_x, force_y, in_contact, output ready);
endinterface

/* sv/pair_contact_force.sv */
// Linear spring-dashpot contact force between two discs, fully pipelined.
// Stages: 3 setup, 31 square root, 17 divider, 6 force stages and the output register;
// the first setup stage is loaded by the edge that accepts the pair beat.
// Throughput: one pair per cycle; the whole pipe holds only when the output skid is full.
// Reset (synchronous): clears all valid bits and the output buffer, radius to 1.0,
// coefficients to zero. No clearing pass.
module pair_contact_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  pcf_pair_if.sink           pairs,
  pcf_force_if.source        forces
);

  localparam int SQL = pcf_pkg::SQ_STEPS - 1;
  localparam int DVL = pcf_pkg::DIV_STEPS - 1;

  // ---------------------------------------------------------------- config
  logic [29:0] particle_radius;
  logic [30:0] spring_stiffness;
  logic [30:0] normal_damping;
  logic [30:0] shear_friction;
  logic [30:0] collide;
  logic [61:0] coll_sq;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_radius  <= 30'd65536;
      spring_stiffness <= '0;
      normal_damping   <= '0;
      shear_friction   <= '0;
    end else if (cfg_we) begin
      unique case (pcf_pkg::cfg_reg_t'(cfg_index))
        pcf_pkg::REG_RADIUS: particle_radius  <= cfg_data[29:0];
        pcf_pkg::REG_STIFF:  spring_stiffness <= cfg_data;
        pcf_pkg::REG_DAMP:   normal_damping   <= cfg_data;
        pcf_pkg::REG_FRIC:   shear_friction   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign collide = {particle_radius, 1'b0};

  // Square of the contact distance, refreshed every cycle
  always_ff @(posedge clk) begin
    coll_sq <= collide * collide;
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic ov, sk_v;
  logic e6_v;

  assign en          = !sk_v;
  assign pairs.ready = en;

  // ---------------------------------------------------------------- stage A
  logic               a_v;
  logic signed [32:0] a_dx, a_dy, a_rvx, a_rvy;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= pairs.valid;
  end

  // Take differences of the pair
  always_ff @(posedge clk) begin
    if (en) begin
      a_dx  <= {pairs.pos_b_x[31], pairs.pos_b_x} - {pairs.pos_a_x[31], pairs.pos_a_x};
      a_dy  <= {pairs.pos_b_y[31], pairs.pos_b_y} - {pairs.pos_a_y[31], pairs.pos_a_y};
      a_rvx <= {pairs.vel_b_x[31], pairs.vel_b_x} - {pairs.vel_a_x[31], pairs.vel_a_x};
      a_rvy <= {pairs.vel_b_y[31], pairs.vel_b_y} - {pairs.vel_a_y[31], pairs.vel_a_y};
    end
  end

  // ---------------------------------------------------------------- stage B
  logic                b_v, b_far;
  logic [61:0]         b_sqx, b_sqy;
  pcf_pkg::sq_carry_t  b_c;
  logic [32:0]         adx_w, ady_w;

  assign adx_w = a_dx[32] ? (~a_dx + 33'd1) : a_dx;
  assign ady_w = a_dy[32] ? (~a_dy + 33'd1) : a_dy;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end

  // Reject far pairs, square the offsets
  always_ff @(posedge clk) begin
    if (en) begin
      b_far       <= (adx_w >= {2'b00, collide}) || (ady_w >= {2'b00, collide});
      b_sqx       <= adx_w[30:0] * adx_w[30:0];
      b_sqy       <= ady_w[30:0] * ady_w[30:0];
      b_c.contact <= 1'b0;
      b_c.sx      <= a_dx[32];
      b_c.sy      <= a_dy[32];
      b_c.adx     <= adx_w[30:0];
      b_c.ady     <= ady_w[30:0];
      b_c.rvx     <= a_rvx;
      b_c.rvy     <= a_rvy;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic                c_v;
  logic [61:0]         c_d2;
  pcf_pkg::sq_carry_t  c_c;
  logic [62:0]         d2_w;

  assign d2_w = {1'b0, b_sqx} + {1'b0, b_sqy};

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end

  // Sum squares, decide contact
  always_ff @(posedge clk) begin
    if (en) begin
      c_d2        <= d2_w[61:0];
      c_c.contact <= !b_far && (d2_w != '0) && (d2_w < {1'b0, coll_sq});
      c_c.sx      <= b_c.sx;
      c_c.sy      <= b_c.sy;
      c_c.adx     <= b_c.adx;
      c_c.ady     <= b_c.ady;
      c_c.rvx     <= b_c.rvx;
      c_c.rvy     <= b_c.rvy;
    end
  end

  // ---------------------------------------------------------------- square root
  logic               sq_v    [pcf_pkg::SQ_STEPS];
  logic [32:0]        sq_rem  [pcf_pkg::SQ_STEPS-1];
  logic [30:0]        sq_root [pcf_pkg::SQ_STEPS];
  logic [61:0]        sq_x    [pcf_pkg::SQ_STEPS-1];
  pcf_pkg::sq_carry_t sq_c    [pcf_pkg::SQ_STEPS];
  pcf_pkg::sq_step_t  sq_nx   [pcf_pkg::SQ_STEPS];

  always_comb begin
    sq_nx[0] = pcf_pkg::sqrt_step('0, '0, c_d2[61:60]);
    for (int s = 1; s < pcf_pkg::SQ_STEPS; s++) begin
      sq_nx[s] = pcf_pkg::sqrt_step(sq_rem[s-1], sq_root[s-1], sq_x[s-1][61:60]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < pcf_pkg::SQ_STEPS; s++) sq_v[s] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= c_v;
      for (int s = 1; s < pcf_pkg::SQ_STEPS; s++) sq_v[s] <= sq_v[s-1];
    end
  end

  // Advance one root digit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= sq_nx[0].rem;
      sq_root[0] <= sq_nx[0].root;
      sq_x[0]    <= {c_d2[59:0], 2'b00};
      sq_c[0]    <= c_c;
      for (int s = 1; s < pcf_pkg::SQ_STEPS; s++) begin
        sq_root[s] <= sq_nx[s].root;
        sq_c[s]    <= sq_c[s-1];
      end
      for (int s = 1; s < pcf_pkg::SQ_STEPS - 1; s++) begin
        sq_rem[s] <= sq_nx[s].rem;
        sq_x[s]   <= {sq_x[s-1][59:0], 2'b00};
      end
    end
  end

  // ---------------------------------------------------------------- normal divide
  logic               dv_v  [pcf_pkg::DIV_STEPS];
  logic [30:0]        dv_rx [pcf_pkg::DIV_STEPS-1];
  logic [30:0]        dv_ry [pcf_pkg::DIV_STEPS-1];
  logic [16:0]        dv_qx [pcf_pkg::DIV_STEPS];
  logic [16:0]        dv_qy [pcf_pkg::DIV_STEPS];
  pcf_pkg::dv_carry_t dv_c  [pcf_pkg::DIV_STEPS];
  pcf_pkg::dv_step_t  dv_nx [pcf_pkg::DIV_STEPS];
  pcf_pkg::dv_step_t  dv_ny [pcf_pkg::DIV_STEPS];
  logic [30:0]        root_d;

  assign root_d = sq_root[SQL];

  // Quotient of |d| * 2^16 by the distance: top remainder is |d| >> 1, then |d|[0], then zeros
  always_comb begin
    dv_nx[0] = pcf_pkg::div_step({1'b0, sq_c[SQL].adx[30:1]}, sq_c[SQL].adx[0], root_d);
    dv_ny[0] = pcf_pkg::div_step({1'b0, sq_c[SQL].ady[30:1]}, sq_c[SQL].ady[0], root_d);
    for (int k = 1; k < pcf_pkg::DIV_STEPS; k++) begin
      dv_nx[k] = pcf_pkg::div_step(dv_rx[k-1], 1'b0, dv_c[k-1].rdist);
      dv_ny[k] = pcf_pkg::div_step(dv_ry[k-1], 1'b0, dv_c[k-1].rdist);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pcf_pkg::DIV_STEPS; k++) dv_v[k] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQL];
      for (int k = 1; k < pcf_pkg::DIV_STEPS; k++) dv_v[k] <= dv_v[k-1];
    end
  end

  // Advance one quotient bit per stage for both axes
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rx[0]        <= dv_nx[0].rem;
      dv_ry[0]        <= dv_ny[0].rem;
      dv_qx[0]        <= {16'd0, dv_nx[0].q};
      dv_qy[0]        <= {16'd0, dv_ny[0].q};
      dv_c[0].contact <= sq_c[SQL].contact;
      dv_c[0].sx      <= sq_c[SQL].sx;
      dv_c[0].sy      <= sq_c[SQL].sy;
      dv_c[0].rdist   <= root_d;
      dv_c[0].ovl     <= collide - root_d;
      dv_c[0].rvx     <= sq_c[SQL].rvx;
      dv_c[0].rvy     <= sq_c[SQL].rvy;
      for (int k = 1; k < pcf_pkg::DIV_STEPS; k++) begin
        dv_qx[k] <= {dv_qx[k-1][15:0], dv_nx[k].q};
        dv_qy[k] <= {dv_qy[k-1][15:0], dv_ny[k].q};
        dv_c[k]  <= dv_c[k-1];
      end
      for (int k = 1; k < pcf_pkg::DIV_STEPS - 1; k++) begin
        dv_rx[k] <= dv_nx[k].rem;
        dv_ry[k] <= dv_ny[k].rem;
      end
    end
  end

  // ---------------------------------------------------------------- E1: first products
  logic        e1_v, e1_ct, e1_nxn, e1_nyn, e1_sgx, e1_sgy;
  logic [16:0] e1_qx, e1_qy;
  logic [61:0] e1_psp;
  logic [49:0] e1_pvx, e1_pvy;
  logic [32:0] e1_rvx, e1_rvy;
  logic        nxn_w, nyn_w;
  logic [32:0] arvx_w, arvy_w;

  assign nxn_w  = dv_c[DVL].sx && (dv_qx[DVL] != '0);
  assign nyn_w  = dv_c[DVL].sy && (dv_qy[DVL] != '0);
  assign arvx_w = dv_c[DVL].rvx[32] ? (~dv_c[DVL].rvx + 33'd1) : dv_c[DVL].rvx;
  assign arvy_w = dv_c[DVL].rvy[32] ? (~dv_c[DVL].rvy + 33'd1) : dv_c[DVL].rvy;

  always_ff @(posedge clk) begin
    if (rst) e1_v <= 1'b0;
    else if (en) e1_v <= dv_v[DVL];
  end

  // Multiply overlap by stiffness and relative velocity by the normal
  always_ff @(posedge clk) begin
    if (en) begin
      e1_ct  <= dv_c[DVL].contact;
      e1_qx  <= dv_qx[DVL];
      e1_qy  <= dv_qy[DVL];
      e1_nxn <= nxn_w;
      e1_nyn <= nyn_w;
      e1_psp <= dv_c[DVL].ovl * spring_stiffness;
      e1_pvx <= arvx_w * dv_qx[DVL];
      e1_pvy <= arvy_w * dv_qy[DVL];
      e1_sgx <= dv_c[DVL].rvx[32] ^ nxn_w;
      e1_sgy <= dv_c[DVL].rvy[32] ^ nyn_w;
      e1_rvx <= dv_c[DVL].rvx;
      e1_rvy <= dv_c[DVL].rvy;
    end
  end

  // ---------------------------------------------------------------- E2: normal velocity
  logic        e2_v, e2_ct, e2_nxn, e2_nyn;
  logic [16:0] e2_qx, e2_qy;
  logic [45:0] e2_sp;
  logic [33:0] e2_vn;
  logic [32:0] e2_rvx, e2_rvy;
  logic [34:0] tvx_w, tvy_w, vn_w;

  assign tvx_w = e1_sgx ? (35'd0 - {1'b0, e1_pvx[49:16]}) : {1'b0, e1_pvx[49:16]};
  assign tvy_w = e1_sgy ? (35'd0 - {1'b0, e1_pvy[49:16]}) : {1'b0, e1_pvy[49:16]};
  assign vn_w  = tvx_w + tvy_w;

  always_ff @(posedge clk) begin
    if (rst) e2_v <= 1'b0;
    else if (en) e2_v <= e1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_ct  <= e1_ct;
      e2_qx  <= e1_qx;
      e2_qy  <= e1_qy;
      e2_nxn <= e1_nxn;
      e2_nyn <= e1_nyn;
      e2_sp  <= e1_psp[61:16];
      e2_vn  <= vn_w[33:0];
      e2_rvx <= e1_rvx;
      e2_rvy <= e1_rvy;
    end
  end

  // ---------------------------------------------------------------- E3: project on normal
  logic        e3_v, e3_ct, e3_vnn, e3_nxn, e3_nyn, e3_sgx, e3_sgy;
  logic [62:0] e3_psx, e3_psy;
  logic [49:0] e3_pnx, e3_pny;
  logic [32:0] e3_rvx, e3_rvy;
  logic [33:0] avn_w;

  assign avn_w = e2_vn[33] ? (34'd0 - e2_vn) : e2_vn;

  always_ff @(posedge clk) begin
    if (rst) e3_v <= 1'b0;
    else if (en) e3_v <= e2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3_ct  <= e2_ct;
      e3_vnn <= e2_vn[33];
      e3_nxn <= e2_nxn;
      e3_nyn <= e2_nyn;
      e3_psx <= e2_sp * e2_qx;
      e3_psy <= e2_sp * e2_qy;
      e3_pnx <= avn_w[32:0] * e2_qx;
      e3_pny <= avn_w[32:0] * e2_qy;
      e3_sgx <= e2_vn[33] ^ e2_nxn;
      e3_sgy <= e2_vn[33] ^ e2_nyn;
      e3_rvx <= e2_rvx;
      e3_rvy <= e2_rvy;
    end
  end

  // ---------------------------------------------------------------- E4: spring and tangent
  logic        e4_v, e4_ct, e4_vnn;
  logic [46:0] e4_fsx, e4_fsy;
  logic [33:0] e4_nvx, e4_nvy;
  logic [34:0] e4_dvx, e4_dvy;
  logic [33:0] nvx_w, nvy_w;

  assign nvx_w = e3_sgx ? (34'd0 - {1'b0, e3_pnx[48:16]}) : {1'b0, e3_pnx[48:16]};
  assign nvy_w = e3_sgy ? (34'd0 - {1'b0, e3_pny[48:16]}) : {1'b0, e3_pny[48:16]};

  always_ff @(posedge clk) begin
    if (rst) e4_v <= 1'b0;
    else if (en) e4_v <= e3_v;
  end

  // Spring pushes against the normal
  always_ff @(posedge clk) begin
    if (en) begin
      e4_ct  <= e3_ct;
      e4_vnn <= e3_vnn;
      e4_fsx <= e3_nxn ? {1'b0, e3_psx[61:16]} : (47'd0 - {1'b0, e3_psx[61:16]});
      e4_fsy <= e3_nyn ? {1'b0, e3_psy[61:16]} : (47'd0 - {1'b0, e3_psy[61:16]});
      e4_nvx <= nvx_w;
      e4_nvy <= nvy_w;
      e4_dvx <= {{2{e3_rvx[32]}}, e3_rvx} - {nvx_w[33], nvx_w};
      e4_dvy <= {{2{e3_rvy[32]}}, e3_rvy} - {nvy_w[33], nvy_w};
    end
  end

  // ---------------------------------------------------------------- E5: coefficient products
  logic        e5_v, e5_ct, e5_vnn, e5_sdx, e5_sdy, e5_sfx, e5_sfy;
  logic [46:0] e5_fsx, e5_fsy;
  logic [63:0] e5_pdx, e5_pdy;
  logic [64:0] e5_pfx, e5_pfy;
  logic [33:0] anvx_w, anvy_w;
  logic [34:0] advx_w, advy_w;

  assign anvx_w = e4_nvx[33] ? (34'd0 - e4_nvx) : e4_nvx;
  assign anvy_w = e4_nvy[33] ? (34'd0 - e4_nvy) : e4_nvy;
  assign advx_w = e4_dvx[34] ? (35'd0 - e4_dvx) : e4_dvx;
  assign advy_w = e4_dvy[34] ? (35'd0 - e4_dvy) : e4_dvy;

  always_ff @(posedge clk) begin
    if (rst) e5_v <= 1'b0;
    else if (en) e5_v <= e4_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e5_ct  <= e4_ct;
      e5_vnn <= e4_vnn;
      e5_fsx <= e4_fsx;
      e5_fsy <= e4_fsy;
      e5_pdx <= anvx_w[32:0] * normal_damping;
      e5_pdy <= anvy_w[32:0] * normal_damping;
      e5_pfx <= advx_w[33:0] * shear_friction;
      e5_pfy <= advy_w[33:0] * shear_friction;
      e5_sdx <= e4_nvx[33];
      e5_sdy <= e4_nvy[33];
      e5_sfx <= e4_dvx[34];
      e5_sfy <= e4_dvy[34];
    end
  end

  // ---------------------------------------------------------------- E6: sum and saturate
  logic        e6_ct;
  logic [31:0] e6_fx, e6_fy;
  logic [48:0] dmx_w, dmy_w;
  logic [49:0] frx_w, fry_w;
  logic [51:0] sx_w, sy_w;
  logic [31:0] satx_w, saty_w;

  assign dmx_w = e5_sdx ? (49'd0 - {1'b0, e5_pdx[63:16]}) : {1'b0, e5_pdx[63:16]};
  assign dmy_w = e5_sdy ? (49'd0 - {1'b0, e5_pdy[63:16]}) : {1'b0, e5_pdy[63:16]};
  assign frx_w = e5_sfx ? (50'd0 - {1'b0, e5_pfx[64:16]}) : {1'b0, e5_pfx[64:16]};
  assign fry_w = e5_sfy ? (50'd0 - {1'b0, e5_pfy[64:16]}) : {1'b0, e5_pfy[64:16]};

  // Damping acts only while approaching
  assign sx_w = {{5{e5_fsx[46]}}, e5_fsx}
              + (e5_vnn ? {{3{dmx_w[48]}}, dmx_w} : 52'd0)
              + {{2{frx_w[49]}}, frx_w};
  assign sy_w = {{5{e5_fsy[46]}}, e5_fsy}
              + (e5_vnn ? {{3{dmy_w[48]}}, dmy_w} : 52'd0)
              + {{2{fry_w[49]}}, fry_w};

  always_comb begin
    if (!sx_w[51] && (sx_w[50:31] != '0))      satx_w = pcf_pkg::FORCE_MAX;
    else if (sx_w[51] && (sx_w[50:31] != '1))  satx_w = pcf_pkg::FORCE_MIN;
    else                                       satx_w = sx_w[31:0];
    if (!sy_w[51] && (sy_w[50:31] != '0))      saty_w = pcf_pkg::FORCE_MAX;
    else if (sy_w[51] && (sy_w[50:31] != '1))  saty_w = pcf_pkg::FORCE_MIN;
    else                                       saty_w = sy_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) e6_v <= 1'b0;
    else if (en) e6_v <= e5_v;
  end

  // Drop the force outside contact
  always_ff @(posedge clk) begin
    if (en) begin
      e6_ct <= e5_ct;
      e6_fx <= e5_ct ? satx_w : 32'd0;
      e6_fy <= e5_ct ? saty_w : 32'd0;
    end
  end

  // ---------------------------------------------------------------- output and skid
  logic        push, pop;
  logic [31:0] o_fx, o_fy, s_fx, s_fy;
  logic        o_ct, s_ct;

  assign push = en && e6_v;
  assign pop  = ov && forces.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      sk_v <= 1'b0;
    end else if (pop) begin
      if (sk_v) begin
        sk_v <= 1'b0;
      end else if (!push) begin
        ov <= 1'b0;
      end
    end else if (push) begin
      if (!ov) ov <= 1'b1;
      else sk_v <= 1'b1;
    end
  end

  // Move beats between pipe, skid and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      if (sk_v) begin
        o_fx <= s_fx;
        o_fy <= s_fy;
        o_ct <= s_ct;
      end else if (push) begin
        o_fx <= e6_fx;
        o_fy <= e6_fy;
        o_ct <= e6_ct;
      end
    end else if (push) begin
      if (!ov) begin
        o_fx <= e6_fx;
        o_fy <= e6_fy;
        o_ct <= e6_ct;
      end else begin
        s_fx <= e6_fx;
        s_fy <= e6_fy;
        s_ct <= e6_ct;
      end
    end
  end

  assign forces.valid      = ov;
  assign forces.force_x    = o_fx;
  assign forces.force_y    = o_fy;
  assign forces.in_contact = o_ct;

endmodule

/* verif/pair_contact_force_tb.sv */
// Testbench for the pair contact force block: a self-checking stream of particle pairs.
`timescale 1ns / 1ps

module pair_contact_force_tb;

  localparam longint SAT_LIM  = 64'sd1 <<< 60;
  localparam int     PIPE_LAT = 57;

  typedef struct {
    logic signed [31:0] pax, pay, vax, vay, pbx, pby, vbx, vby;
  } pair_t;

  typedef struct {
    logic signed [31:0] fx, fy;
    logic               contact;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = pcf_pkg::REG_RADIUS;
  logic [30:0] cfg_data  = '0;

  pcf_pair_if  pair_bus();
  pcf_force_if force_bus();

  pair_contact_force u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pairs(pair_bus.sink), .forces(force_bus.source)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers
  longint unsigned radius_q, stiff_q, damp_q, fric_q;
  force_t expected_forces[$];
  int     tx_idle = 0, rx_idle = 0, rx_hold = 0;
  int     errors = 0, checked = 0, contacts = 0, sent = 0;

  function automatic longint clip60(longint v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Fixed-point product, truncated toward zero, saturated at 2^60
  function automatic longint qmul(longint a, longint b);
    logic neg;
    longint unsigned ma, mb, hi, lo, t, r;
    neg = (a < 0) != (b < 0);
    ma = magn(clip60(a));
    mb = magn(b);
    if (mb > 64'hFFFF_FFFF) mb = 64'hFFFF_FFFF;
    hi = ma >> 32;
    lo = ma & 64'hFFFF_FFFF;
    t = hi * mb;
    if (t > (longint'(SAT_LIM) >> 16)) r = SAT_LIM;
    else r = (t << 16) + ((lo * mb) >> 16);
    if (r > SAT_LIM) r = SAT_LIM;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat_word(longint v);
    if (v > 64'sd2147483647) return pcf_pkg::FORCE_MAX;
    if (v < -64'sd2147483648) return pcf_pkg::FORCE_MIN;
    return v[31:0];
  endfunction

  function automatic force_t contact_force(pair_t p);
    force_t f;
    longint dx, dy, nx, ny, ovl, sp, fx, fy, rvx, rvy, vn, nvx, nvy;
    longint unsigned collide, adx, ady, d2, root_d;
    f.fx = '0; f.fy = '0; f.contact = 1'b0;
    dx = clip60(longint'(p.pbx) - longint'(p.pax));
    dy = clip60(longint'(p.pby) - longint'(p.pay));
    collide = radius_q * 2;
    adx = magn(dx);
    ady = magn(dy);
    if (adx >= collide || ady >= collide) return f;
    d2 = adx * adx + ady * ady;
    if (d2 == 0 || d2 >= collide * collide) return f;
    root_d = int_sqrt(d2);
    nx = (dx * 65536) / longint'(root_d);
    ny = (dy * 65536) / longint'(root_d);
    ovl = longint'(collide - root_d);
    sp = qmul(ovl, longint'(stiff_q));
    fx = -qmul(sp, nx);
    fy = -qmul(sp, ny);
    rvx = clip60(longint'(p.vbx) - longint'(p.vax));
    rvy = clip60(longint'(p.vby) - longint'(p.vay));
    vn = clip60(qmul(rvx, nx) + qmul(rvy, ny));
    nvx = qmul(vn, nx);
    nvy = qmul(vn, ny);
    // damping only while approaching
    if (vn < 0) begin
      fx += qmul(nvx, longint'(damp_q));
      fy += qmul(nvy, longint'(damp_q));
    end
    fx += qmul(clip60(rvx - nvx), longint'(fric_q));
    fy += qmul(clip60(rvy - nvy), longint'(fric_q));
    f.fx = sat_word(fx);
    f.fy = sat_word(fy);
    f.contact = 1'b1;
    return f;
  endfunction

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      force_bus.ready <= 1'b0;
    end else begin
      force_bus.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    force_t e;
    if (!rst && force_bus.valid && force_bus.ready) begin
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected result beat fx=%0d fy=%0d c=%0b", $time,
                 force_bus.force_x, force_bus.force_y, force_bus.in_contact);
        errors++;
      end else begin
        e = expected_forces.pop_front();
        checked++;
        if (e.contact) contacts++;
        if (force_bus.force_x !== e.fx) begin
          $display("%0t: force_x expected %0d actual %0d", $time, e.fx, force_bus.force_x);
          errors++;
        end
        if (force_bus.force_y !== e.fy) begin
          $display("%0t: force_y expected %0d actual %0d", $time, e.fy, force_bus.force_y);
          errors++;
        end
        if (force_bus.in_contact !== e.contact) begin
          $display("%0t: in_contact expected %0b actual %0b", $time, e.contact,
                   force_bus.in_contact);
          errors++;
        end
      end
    end
  end

  // Offer one pair beat, with optional idle cycles ahead of it
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < tx_idle) begin
      pair_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pair_bus.valid   <= 1'b1;
    pair_bus.pos_a_x <= p.pax; pair_bus.pos_a_y <= p.pay;
    pair_bus.vel_a_x <= p.vax; pair_bus.vel_a_y <= p.vay;
    pair_bus.pos_b_x <= p.pbx; pair_bus.pos_b_y <= p.pby;
    pair_bus.vel_b_x <= p.vbx; pair_bus.vel_b_y <= p.vby;
    do @(posedge clk); while (!pair_bus.ready);
    expected_forces.push_back(contact_force(p));
    sent++;
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain();
    pair_bus.valid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);
  endtask

  task automatic write_reg(pcf_pkg::cfg_reg_t idx, longint unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pcf_pkg::REG_RADIUS: radius_q = val & 64'h3FFF_FFFF;
      pcf_pkg::REG_STIFF:  stiff_q  = val & 64'h7FFF_FFFF;
      pcf_pkg::REG_DAMP:   damp_q   = val & 64'h7FFF_FFFF;
      default:             fric_q   = val & 64'h7FFF_FFFF;
    endcase
  endtask

  task automatic set_coeffs(longint unsigned rad, longint unsigned k,
                            longint unsigned d, longint unsigned mu);
    write_reg(pcf_pkg::REG_RADIUS, rad);
    write_reg(pcf_pkg::REG_STIFF, k);
    write_reg(pcf_pkg::REG_DAMP, d);
    write_reg(pcf_pkg::REG_FRIC, mu);
  endtask

  function automatic logic signed [31:0] rnd_vel();
    case ($urandom_range(3))
      0:       return $urandom();
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Mostly pairs near contact, the rest full-range noise
  function automatic pair_t rnd_pair();
    pair_t p;
    longint span;
    p.vax = rnd_vel(); p.vay = rnd_vel(); p.vbx = rnd_vel(); p.vby = rnd_vel();
    if ($urandom_range(99) < 25) begin
      p.pax = $urandom(); p.pay = $urandom(); p.pbx = $urandom(); p.pby = $urandom();
      return p;
    end
    span = longint'(radius_q) * 2 + 2;
    if (span > 64'sd2000000000) span = 64'sd2000000000;
    p.pax = $signed($urandom()) >>> $urandom_range(1, 8);
    p.pay = $signed($urandom()) >>> $urandom_range(1, 8);
    p.pbx = p.pax + 32'(longint'({$urandom(), $urandom()} % (2 * span)) - span);
    p.pby = p.pay + 32'(longint'({$urandom(), $urandom()} % (2 * span)) - span);
    return p;
  endfunction

  function automatic pair_t mk(int pax, int pay, int pbx, int pby,
                               int vax, int vay, int vbx, int vby);
    pair_t p;
    p.pax = pax; p.pay = pay; p.pbx = pbx; p.pby = pby;
    p.vax = vax; p.vay = vay; p.vbx = vbx; p.vby = vby;
    return p;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_pair(rnd_pair());
  endtask

  // Edge cases: coincident, far apart, boundary, approach and recede, extremes
  task automatic test_directed();
    set_coeffs(32'h0001_0000, 32'h0010_0000, 32'h0002_0000, 32'h0000_8000);
    send_pair(mk(0, 0, 0, 0, 100, 0, -100, 0));
    send_pair(mk(0, 0, 32'h0002_0000, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 32'h0001_FFFF, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, -32'sh0001_FFFF, 0, 0, 0, 0));
    send_pair(mk(0, 0, 32'h0001_6A09, 32'h0001_6A0A, 0, 0, 0, 0));
    send_pair(mk(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, -32'sh0001_0000, 0));
    send_pair(mk(0, 0, 32'h0001_0000, 0, -32'sh0001_0000, 0, 32'h0001_0000, 0));
    send_pair(mk(0, 0, 32'h0000_8000, 32'h0000_8000, 0, 32'h0003_0000, 0, -32'sh0002_0000));
    send_pair(mk(0, 0, 1, 0, 0, 0, 0, 0));
    send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_pair(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFF0, 32'h8000_0010,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    // saturate the force words
    set_coeffs(32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(mk(0, 0, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_pair(mk(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 32'h4000_0000, -32'sh4000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0));
    send_pair(mk(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
    // zero radius never touches
    set_coeffs(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pair(mk(0, 0, 1, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Walk through register settings, extremes among them
  task automatic test_config_sweep();
    set_coeffs(32'h0001_0000, 32'h0004_0000, 32'h0000_8000, 32'h0000_4000);
    run_random(100);
    set_coeffs(32'h3FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 0);
    run_random(100);
    set_coeffs(32'h0000_0100, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    run_random(100);
    set_coeffs(32'h0100_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    run_random(100);
    set_coeffs(32'h0000_0001, 32'h1234_5678, 32'h0765_4321, 32'h0011_2233);
    run_random(100);
    set_coeffs($urandom_range(32'h10000, 32'h3FFF_FFFF), $urandom(), $urandom(), $urandom());
    run_random(100);
  endtask

  // Idle on each side in turn, then run flat out
  task automatic test_idling();
    set_coeffs(32'h0004_0000, 32'h0008_0000, 32'h0001_8000, 32'h0000_C000);
    tx_idle = 31; rx_idle = 72;
    run_random(120);
    tx_idle = 72; rx_idle = 31;
    run_random(120);
    tx_idle = 0; rx_idle = 0;
    run_random(120);
  endtask

  // Hold the receiver off long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    tx_idle = 0; rx_idle = 0;
    rx_hold = 400;
    run_random(150);
    drain();
    run_random(30);
  endtask

  initial begin
    pair_bus.valid = 1'b0;
    pair_bus.pos_a_x = '0; pair_bus.pos_a_y = '0; pair_bus.vel_a_x = '0; pair_bus.vel_a_y = '0;
    pair_bus.pos_b_x = '0; pair_bus.pos_b_y = '0; pair_bus.vel_b_x = '0; pair_bus.vel_b_y = '0;
    force_bus.ready = 1'b0;
    radius_q = 65536; stiff_q = 0; damp_q = 0; fric_q = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_idling();
    test_backpressure();
    drain();
    $display("Sent %0d pairs over several register settings and idle patterns;", sent);
    $display("checked %0d forces, %0d of them in contact.", checked, contacts);
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("[pair_contact_force] OK");
    end else begin
      $display("[pair_contact_force] ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("[pair_contact_force] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
sv/pcf_pkg.sv
sv/pcf_if.sv
sv/pair_contact_force.sv
verif/pair_contact_force_tb.sv
